### rtl/csp_pkg.sv
// shared types and constants of the call stack time profiler
package csp_pkg;

    localparam int CSP_STACK_DEPTH = 64;
    localparam int DATA_W          = 64;
    localparam int DEPTH_W         = 6;
    localparam int TAG_W           = 22;
    localparam int CFG_IDX_W       = 1;
    localparam int CFG_DATA_W      = 22;
    localparam int QUEUE_DEPTH     = 2;

    localparam logic [CFG_IDX_W-1:0] CFG_RECORDING_ENABLE = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_THREAD_TAG       = 1'b1;

    localparam logic MODE_ENTRY = 1'b0;
    localparam logic MODE_EXIT  = 1'b1;

    typedef enum logic [1:0] {
        ST_CALL     = 2'd0,
        ST_EMPTY    = 2'd1,
        ST_MISMATCH = 2'd2,
        ST_OVERFLOW = 2'd3
    } t_status;

    typedef enum logic [1:0] {
        OP_PUSH,
        OP_POP,
        OP_EMPTY,
        OP_OVERFLOW
    } t_op;

    typedef struct packed {
        t_op               op;
        logic [DATA_W-1:0] pc;
        logic [DATA_W-1:0] ts;
    } t_cmd;

    typedef enum logic [1:0] {
        B_IDLE,
        B_CALC,
        B_OUT
    } t_bstate;

endpackage

### rtl/csp_front.sv
// front end: takes items, tracks stack depth and classifies each event
module csp_front import csp_pkg::*; #(
    parameter int STACK_DEPTH = CSP_STACK_DEPTH,
    localparam int AW = $clog2(STACK_DEPTH),
    localparam int CW = $clog2(STACK_DEPTH + 1)
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    input  logic              i_full,
    input  logic              i_enable,
    input  logic              i_mode,
    input  logic [DATA_W-1:0] i_pc,
    input  logic [DATA_W-1:0] i_ts,
    output logic              o_stall,
    output logic              o_push,
    output t_cmd              o_cmd,
    output logic [AW-1:0]     o_idx
);

    logic [CW-1:0] r_count;
    logic [CW-1:0] n_count;
    logic [CW-1:0] w_dec;
    logic          w_accept;

    assign o_stall  = i_full;
    assign w_accept = i_valid && !i_full;
    assign w_dec    = r_count - 1'b1;

    always_comb begin
        n_count    = r_count;
        o_push     = 1'b0;
        o_cmd.op   = OP_PUSH;
        o_cmd.pc   = i_pc;
        o_cmd.ts   = i_ts;
        o_idx      = r_count[AW-1:0];
        if (w_accept && i_enable) begin
            o_push = 1'b1;
            if (i_mode == MODE_ENTRY) begin
                if (r_count >= CW'(STACK_DEPTH)) begin
                    o_cmd.op = OP_OVERFLOW;
                end else begin
                    n_count = r_count + 1'b1;
                end
            end else if (r_count == '0) begin
                o_cmd.op = OP_EMPTY;
            end else begin
                o_cmd.op = OP_POP;
                o_idx    = w_dec[AW-1:0];
                n_count  = w_dec;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
        end else begin
            r_count <= n_count;
        end
    end

    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CW'(STACK_DEPTH))
        else $error("stack count beyond depth");

    a_pop_dec: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_push && o_cmd.op == OP_POP) |=> (r_count == $past(r_count) - 1'b1))
        else $error("pop did not lower the stack count");

endmodule

### rtl/csp_queue.sv
// two-entry queue between front end and stack engine
module csp_queue import csp_pkg::*; #(
    parameter int W = 8
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_push,
    input  logic [W-1:0] i_data,
    input  logic         i_pop,
    output logic         o_full,
    output logic         o_valid,
    output logic [W-1:0] o_data
);

    localparam int PW = $clog2(QUEUE_DEPTH);
    localparam int NW = $clog2(QUEUE_DEPTH + 1);

    logic [W-1:0]  r_data [QUEUE_DEPTH];
    logic [PW-1:0] r_wr_ptr;
    logic [PW-1:0] r_rd_ptr;
    logic [NW-1:0] r_cnt;
    logic          w_push;
    logic          w_pop;

    assign o_full  = (r_cnt == NW'(QUEUE_DEPTH));
    assign o_valid = (r_cnt != '0);
    assign o_data  = r_data[r_rd_ptr];
    assign w_push  = i_push && !o_full;
    assign w_pop   = i_pop && o_valid;

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_data[r_wr_ptr] <= i_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_cnt    <= '0;
        end else begin
            if (w_push) begin
                r_wr_ptr <= (r_wr_ptr == PW'(QUEUE_DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
            end
            if (w_pop) begin
                r_rd_ptr <= (r_rd_ptr == PW'(QUEUE_DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
            end
            r_cnt <= r_cnt + NW'(w_push) - NW'(w_pop);
        end
    end

endmodule

### rtl/csp_back.sv
// stack engine: frame memories, timing arithmetic and result register
module csp_back import csp_pkg::*; #(
    parameter int STACK_DEPTH = CSP_STACK_DEPTH,
    localparam int AW = $clog2(STACK_DEPTH)
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_q_valid,
    input  t_cmd              i_q_cmd,
    input  logic [AW-1:0]     i_q_idx,
    output logic              o_q_pop,
    input  logic [TAG_W-1:0]  i_thread_tag,
    output logic              o_out_valid,
    input  logic              i_out_stall,
    output logic [1:0]        o_status,
    output logic [DATA_W-1:0] o_event_pc,
    output logic [DATA_W-1:0] o_start_time,
    output logic [DATA_W-1:0] o_inclusive_time,
    output logic [DATA_W-1:0] o_exclusive_time,
    output logic [DEPTH_W-1:0] o_call_depth,
    output logic [TAG_W-1:0]  o_thread_id
);

    logic [DATA_W-1:0] mem_addr  [STACK_DEPTH];
    logic [DATA_W-1:0] mem_start [STACK_DEPTH];
    logic [DATA_W-1:0] mem_child [STACK_DEPTH];

    t_bstate           r_state;
    t_bstate           n_state;
    t_op               r_op;
    logic [DATA_W-1:0] r_pc;
    logic [DATA_W-1:0] r_ts;
    logic [AW-1:0]     r_idx;
    logic [DATA_W-1:0] r_rd_addr;
    logic [DATA_W-1:0] r_rd_start;
    logic [DATA_W-1:0] r_rd_child;
    logic [DATA_W-1:0] r_rd_parent;
    logic [DATA_W-1:0] r_incl;
    logic              r_match;

    logic              w_take;
    logic              w_push_wr;
    logic              w_load;
    logic              w_parent_wr;
    logic              w_out_free;
    logic [AW-1:0]     w_q_parent;
    logic [AW-1:0]     w_parent;
    logic [DATA_W-1:0] w_excl;
    logic [DATA_W-1:0] w_parent_sum;
    logic              w_call;

    assign w_out_free   = !o_out_valid || !i_out_stall;
    assign w_q_parent   = i_q_idx - 1'b1;
    assign w_parent     = r_idx - 1'b1;
    assign w_excl       = (r_incl > r_rd_child) ? (r_incl - r_rd_child) : '0;
    assign w_parent_sum = r_rd_parent + r_incl;
    assign w_call       = (r_op == OP_POP) && r_match;

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            B_IDLE: begin
                if (i_q_valid) begin
                    unique case (i_q_cmd.op)
                        OP_PUSH:                n_state = B_IDLE;
                        OP_POP:                 n_state = B_CALC;
                        OP_EMPTY, OP_OVERFLOW:  n_state = B_OUT;
                        default:                n_state = B_IDLE;
                    endcase
                end
            end
            B_CALC:  n_state = B_OUT;
            B_OUT: begin
                if (w_out_free) begin
                    n_state = B_IDLE;
                end
            end
            default: n_state = B_IDLE;
        endcase
    end

    always_comb begin
        w_take      = 1'b0;
        w_push_wr   = 1'b0;
        w_load      = 1'b0;
        w_parent_wr = 1'b0;
        unique case (r_state)
            B_IDLE: begin
                w_take    = i_q_valid;
                w_push_wr = i_q_valid && (i_q_cmd.op == OP_PUSH);
            end
            B_CALC: begin
            end
            B_OUT: begin
                w_load      = w_out_free;
                w_parent_wr = w_out_free && w_call && (r_idx != '0);
            end
            default: begin
            end
        endcase
    end

    assign o_q_pop = w_take;

    // frame memories
    always_ff @(posedge i_clk) begin
        if (w_push_wr) begin
            mem_addr[i_q_idx]  <= i_q_cmd.pc;
            mem_start[i_q_idx] <= i_q_cmd.ts;
        end
        if (w_push_wr) begin
            mem_child[i_q_idx] <= '0;
        end else if (w_parent_wr) begin
            mem_child[w_parent] <= w_parent_sum;
        end
        if (w_take) begin
            r_rd_addr   <= mem_addr[i_q_idx];
            r_rd_start  <= mem_start[i_q_idx];
            r_rd_child  <= mem_child[i_q_idx];
            r_rd_parent <= mem_child[w_q_parent];
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_take) begin
            r_op  <= i_q_cmd.op;
            r_pc  <= i_q_cmd.pc;
            r_ts  <= i_q_cmd.ts;
            r_idx <= i_q_idx;
        end
        if (r_state == B_CALC) begin
            r_incl  <= r_ts - r_rd_start;
            r_match <= (r_rd_addr == r_pc);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= B_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_out_valid <= 1'b0;
        end else if (w_load) begin
            o_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            o_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_load) begin
            o_thread_id      <= i_thread_tag;
            o_event_pc       <= '0;
            o_start_time     <= '0;
            o_inclusive_time <= '0;
            o_exclusive_time <= '0;
            o_call_depth     <= '0;
            case (r_op)
                OP_POP: begin
                    if (r_match) begin
                        o_status         <= ST_CALL;
                        o_event_pc       <= r_pc;
                        o_start_time     <= r_rd_start;
                        o_inclusive_time <= r_incl;
                        o_exclusive_time <= w_excl;
                        o_call_depth     <= DEPTH_W'(r_idx);
                    end else begin
                        o_status <= ST_MISMATCH;
                    end
                end
                OP_EMPTY:    o_status <= ST_EMPTY;
                OP_OVERFLOW: o_status <= ST_OVERFLOW;
                default:     o_status <= ST_EMPTY;
            endcase
        end
    end

    a_no_push_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == B_OUT) |-> (r_op != OP_PUSH))
        else $error("push command reached the result stage");

    a_load_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == B_OUT && w_load) |=> (r_state == B_IDLE && o_out_valid))
        else $error("result load did not return to idle");

    a_status_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_status != ST_CALL) |->
        (o_event_pc == '0 && o_inclusive_time == '0 && o_call_depth == '0))
        else $error("status result carries call data");

endmodule

### rtl/call_stack_time_profiler.sv
// top level of the call stack time profiler
// Shadow call stack profiler. Entry and exit items are taken one per cycle
// into a two-entry queue whenever it has room; the stack engine behind it
// writes an entry's frame on taking it, sends an empty-stack or overflow
// status to its output state and runs an exit through its calc and output
// states (frame read, inclusive time, exclusive time, parent update by a
// read-modify-write of the parent frame's child time). A result waits in
// an output register while the next item is taken. With recording disabled
// items are accepted and dropped. Frame memories need no clearing pass.
module call_stack_time_profiler import csp_pkg::*; #(
    parameter int STACK_DEPTH = CSP_STACK_DEPTH
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_in_valid,
    output logic                  o_in_stall,
    input  logic                  i_mode,
    input  logic [DATA_W-1:0]     i_function_pc,
    input  logic [DATA_W-1:0]     i_timestamp_ns,
    output logic                  o_out_valid,
    input  logic                  i_out_stall,
    output logic [1:0]            o_status,
    output logic [DATA_W-1:0]     o_event_pc,
    output logic [DATA_W-1:0]     o_start_time,
    output logic [DATA_W-1:0]     o_inclusive_time,
    output logic [DATA_W-1:0]     o_exclusive_time,
    output logic [DEPTH_W-1:0]    o_call_depth,
    output logic [TAG_W-1:0]      o_thread_id,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data
);

    localparam int AW = $clog2(STACK_DEPTH);
    localparam int QW = $bits(t_cmd) + AW;

    logic             r_recording_enable;
    logic [TAG_W-1:0] r_thread_tag;

    logic             w_push;
    t_cmd             w_cmd;
    logic [AW-1:0]    w_idx;
    logic             w_full;
    logic             w_q_valid;
    logic [QW-1:0]    w_q_data;
    logic             w_q_pop;
    t_cmd             w_q_cmd;
    logic [AW-1:0]    w_q_idx;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_recording_enable <= 1'b1;
            r_thread_tag       <= '0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                CFG_RECORDING_ENABLE: r_recording_enable <= i_cfg_data[0];
                CFG_THREAD_TAG:       r_thread_tag       <= i_cfg_data[TAG_W-1:0];
                default: begin
                end
            endcase
        end
    end

    csp_front #(
        .STACK_DEPTH (STACK_DEPTH)
    ) u_front (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (i_in_valid),
        .i_full   (w_full),
        .i_enable (r_recording_enable),
        .i_mode   (i_mode),
        .i_pc     (i_function_pc),
        .i_ts     (i_timestamp_ns),
        .o_stall  (o_in_stall),
        .o_push   (w_push),
        .o_cmd    (w_cmd),
        .o_idx    (w_idx)
    );

    csp_queue #(
        .W (QW)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_data  ({w_cmd, w_idx}),
        .i_pop   (w_q_pop),
        .o_full  (w_full),
        .o_valid (w_q_valid),
        .o_data  (w_q_data)
    );

    assign w_q_cmd = t_cmd'(w_q_data[QW-1:AW]);
    assign w_q_idx = w_q_data[AW-1:0];

    csp_back #(
        .STACK_DEPTH (STACK_DEPTH)
    ) u_back (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_q_valid        (w_q_valid),
        .i_q_cmd          (w_q_cmd),
        .i_q_idx          (w_q_idx),
        .o_q_pop          (w_q_pop),
        .i_thread_tag     (r_thread_tag),
        .o_out_valid      (o_out_valid),
        .i_out_stall      (i_out_stall),
        .o_status         (o_status),
        .o_event_pc       (o_event_pc),
        .o_start_time     (o_start_time),
        .o_inclusive_time (o_inclusive_time),
        .o_exclusive_time (o_exclusive_time),
        .o_call_depth     (o_call_depth),
        .o_thread_id      (o_thread_id)
    );

endmodule
